>>> rtl/cbq_pkg.sv
// Shared types and constants for the cascaded biquad filter.
// Holds the coefficient ROM, the tap and state codes, and the command struct.
// No dependencies.
package cbq_pkg;

  // Coefficient format Q2.30
  localparam int COEF_BITS    = 32;
  localparam int COEF_FRAC    = COEF_BITS - 2;
  localparam int ROM_SECTIONS = 6;
  localparam int TAPS         = 5;
  localparam int GUARD_BITS   = 8;   // internal Q9 vs sample Q1
  localparam int CNT_BITS     = 3;   // section_count register width
  localparam logic [CNT_BITS-1:0] CNT_RESET = 3'd6;

  // Multiply-accumulate step order within one section
  typedef enum logic [2:0] {
    TAP_B0,
    TAP_B1,
    TAP_B2,
    TAP_A1,
    TAP_A2
  } tap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_SAT,
    ST_PUSH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;    // capture new sample, clear clip flag
    logic rd_en;    // read one history row
    logic load_h;   // take row entries from read data
    logic mac_en;   // one multiply-accumulate step
    tap_t tap;      // which product
    logic sat;      // finish section, write its history row
    logic push;     // write last row, load output register
    logic clear;    // invalidate all history rows
  } dp_cmd_t;

  // b0 b1 b2 -a1 -a2 per section, Q2.30, feedback terms already negated
  localparam logic signed [COEF_BITS-1:0] COEF_TABLE [ROM_SECTIONS][TAPS] = '{
    '{ 32'sd210461,     32'sd338536,      32'sd210461,
       32'sd1607938603, -32'sd622219884 },
    '{ 32'sd1073741824, 32'sd176633089,   32'sd1073741824,
       32'sd1545118458, -32'sd712101834 },
    '{ 32'sd1073741824, -32'sd635848703,  32'sd1073741824,
       32'sd1462886176, -32'sd832213075 },
    '{ 32'sd1073741824, -32'sd974407957,  32'sd1073741824,
       32'sd1398263089, -32'sd933259437 },
    '{ 32'sd1073741824, -32'sd1118597754, 32'sd1073741824,
       32'sd1363136151, -32'sd1003604186 },
    '{ 32'sd1073741824, -32'sd1173344639, 32'sd1073741824,
       32'sd1357796863, -32'sd1052613791 }
  };

  // Coefficient lookup; sections past the table are all zero
  function automatic logic signed [COEF_BITS-1:0] coef_rom(input logic [4:0] sec,
                                                          input tap_t tap);
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    if (sec < 5'(ROM_SECTIONS) && tap <= TAP_A2) begin
      c = COEF_TABLE[sec[2:0]][tap];
    end
    return c;
  endfunction

endpackage

>>> rtl/cascaded_biquad_iir_filter.sv
// One request at a time: in_stall stays high until the result of the last request
// has been loaded into the output register. The N sections in use (N = section
// count, clamped to MAX_SECTIONS) run in turn; each is five products on one
// shared multiplier plus a round, saturate and history write step.
// Reset (synchronous) sets the count to six and marks all history rows as zero
// through per-row valid bits; no clearing pass. A count write clears them too.
module cascaded_biquad_iir_filter #(
  parameter int MAX_SECTIONS = 7,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  sample_out,
  output logic                           clipped,
  input  logic                           cfg_wr_en,
  input  logic [cbq_pkg::CNT_BITS-1:0]   cfg_wr_data
);

  localparam int SEC_W = $clog2(MAX_SECTIONS + 1);

  cbq_pkg::dp_cmd_t cmd;
  logic [SEC_W-1:0] rd_row;
  logic [SEC_W-1:0] sec;

  // Sequencer
  cbq_ctrl #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .rd_row     (rd_row),
    .sec        (sec)
  );

  // History, MAC and output register
  cbq_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_row    (rd_row),
    .sec       (sec),
    .sample_in (sample_in),
    .sample_out(sample_out),
    .clipped   (clipped)
  );

endmodule

>>> rtl/cbq_datapath.sv
// Datapath of the cascaded biquad filter: history memory, shared MAC,
// saturation and output register. Uses cbq_pkg; driven by cbq_ctrl.
module cbq_datapath #(
  parameter int SAMPLE_BITS  = 24,
  parameter int MAX_SECTIONS = 7
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  cbq_pkg::dp_cmd_t                         cmd,
  input  logic [$clog2(MAX_SECTIONS+1)-1:0]        rd_row,
  input  logic [$clog2(MAX_SECTIONS+1)-1:0]        sec,
  input  logic signed [SAMPLE_BITS-1:0]            sample_in,
  output logic signed [SAMPLE_BITS-1:0]            sample_out,
  output logic                                     clipped
);

  localparam int ROWS   = MAX_SECTIONS + 1;
  localparam int INT_W  = SAMPLE_BITS + cbq_pkg::GUARD_BITS;
  localparam int PROD_W = INT_W + cbq_pkg::COEF_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RES_W  = ACC_W - cbq_pkg::COEF_FRAC;
  localparam logic signed [ACC_W-1:0] BIAS =
    {{(ACC_W - cbq_pkg::COEF_FRAC){1'b0}}, 1'b1, {(cbq_pkg::COEF_FRAC - 1){1'b0}}};

  // History rows: {entry1, entry0}; entry2 of the model is never read
  logic [2*INT_W-1:0] hist [ROWS];
  logic [ROWS-1:0]    row_valid;
  logic [2*INT_W-1:0] rd_q;
  logic               rd_ok;

  logic signed [INT_W-1:0]  x;
  logic signed [INT_W-1:0]  h0;
  logic signed [INT_W-1:0]  h1;
  logic signed [INT_W-1:0]  rd_e0;
  logic signed [INT_W-1:0]  rd_e1;
  logic signed [INT_W-1:0]  mac_op;
  logic signed [cbq_pkg::COEF_BITS-1:0] mac_coef;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  sum;
  logic signed [RES_W-1:0]  res;
  logic                     res_of;
  logic signed [INT_W-1:0]  res_sat;
  logic                     out_of;
  logic signed [SAMPLE_BITS-1:0] out_sat;
  logic                     clip;
  logic                     wr_en;

  // Rows not written since reset or a count change read as zero
  assign rd_e0 = rd_ok ? rd_q[INT_W-1:0] : '0;
  assign rd_e1 = rd_ok ? rd_q[2*INT_W-1:INT_W] : '0;
  assign wr_en = cmd.sat | cmd.push;

  // History memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[sec] <= {h0, x};
    end
    if (cmd.rd_en) begin
      rd_q <= hist[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[sec] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_ok <= row_valid[rd_row];
      end
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (cmd.tap)
      cbq_pkg::TAP_B0: mac_op = x;
      cbq_pkg::TAP_B1: mac_op = h0;
      cbq_pkg::TAP_B2: mac_op = h1;
      cbq_pkg::TAP_A1: mac_op = rd_e0;
      cbq_pkg::TAP_A2: mac_op = rd_e1;
      default:         mac_op = '0;
    endcase
  end

  assign mac_coef = cbq_pkg::coef_rom(5'(sec), cmd.tap);
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign sum      = acc + prod_ext;

  // Round half up was folded in by the bias; floor-shift and saturate
  assign res     = sum[ACC_W-1:cbq_pkg::COEF_FRAC];
  assign res_of  = !((&res[RES_W-1:INT_W-1]) || !(|res[RES_W-1:INT_W-1]));
  assign res_sat = res_of ? (res[RES_W-1] ? {1'b1, {(INT_W-1){1'b0}}}
                                          : {1'b0, {(INT_W-1){1'b1}}})
                          : res[INT_W-1:0];

  // Final output saturation to sample width
  assign out_of  = !((&x[INT_W-1:SAMPLE_BITS-1]) || !(|x[INT_W-1:SAMPLE_BITS-1]));
  assign out_sat = out_of ? (x[INT_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_BITS-1){1'b1}}})
                          : x[SAMPLE_BITS-1:0];

  // Multiply and accumulate
  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      prod <= mac_op * mac_coef;
      if (cmd.tap == cbq_pkg::TAP_B0) begin
        acc <= BIAS;
      end else begin
        acc <= sum;
      end
    end
  end

  // Section input, row entries and clip flag
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x <= {{cbq_pkg::GUARD_BITS{sample_in[SAMPLE_BITS-1]}}, sample_in};
    end else if (cmd.sat) begin
      x <= res_sat;
    end
    if (cmd.load_h) begin
      h0 <= rd_e0;
      h1 <= rd_e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip <= 1'b0;
    end else if (cmd.start) begin
      clip <= 1'b0;
    end else if (cmd.sat) begin
      clip <= clip | res_of;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      sample_out <= out_sat;
      clipped    <= clip | out_of;
    end
  end

endmodule

>>> rtl/cbq_ctrl.sv
// Controller of the cascaded biquad filter: sequences sections and MAC taps,
// holds the section count and the output valid. Uses cbq_pkg.
module cbq_ctrl #(
  parameter int MAX_SECTIONS = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_wr_en,
  input  logic [cbq_pkg::CNT_BITS-1:0]        cfg_wr_data,
  output cbq_pkg::dp_cmd_t                    cmd,
  output logic [$clog2(MAX_SECTIONS+1)-1:0]   rd_row,
  output logic [$clog2(MAX_SECTIONS+1)-1:0]   sec
);

  localparam int SEC_W = $clog2(MAX_SECTIONS + 1);

  cbq_pkg::state_t state, state_next;
  cbq_pkg::tap_t   tap;
  logic [cbq_pkg::CNT_BITS-1:0] section_count;
  logic [SEC_W-1:0] used;
  logic [SEC_W-1:0] sec_inc;
  logic             out_free;

  // Count above the maximum is clamped
  assign used = (32'(section_count) > 32'(MAX_SECTIONS)) ? SEC_W'(MAX_SECTIONS)
                                                         : SEC_W'(section_count);
  assign sec_inc  = sec + SEC_W'(1);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != cbq_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cbq_pkg::ST_IDLE: if (in_valid) begin
        state_next = cbq_pkg::ST_LOAD;
      end
      cbq_pkg::ST_LOAD: begin
        state_next = (used == '0) ? cbq_pkg::ST_PUSH : cbq_pkg::ST_MAC;
      end
      cbq_pkg::ST_MAC: if (tap == cbq_pkg::TAP_A2) begin
        state_next = cbq_pkg::ST_SAT;
      end
      cbq_pkg::ST_SAT: begin
        state_next = (sec_inc == used) ? cbq_pkg::ST_PUSH : cbq_pkg::ST_MAC;
      end
      cbq_pkg::ST_PUSH: if (out_free) begin
        state_next = cbq_pkg::ST_IDLE;
      end
      default: state_next = cbq_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd        = '0;
    cmd.tap    = tap;
    cmd.clear  = cfg_wr_en;
    rd_row     = '0;
    case (state)
      cbq_pkg::ST_IDLE: begin
        cmd.start = in_valid;
        cmd.rd_en = in_valid;
      end
      cbq_pkg::ST_LOAD: begin
        cmd.load_h = 1'b1;
        cmd.rd_en  = (used != '0);
        rd_row     = SEC_W'(1);
      end
      cbq_pkg::ST_MAC: begin
        cmd.mac_en = 1'b1;
      end
      cbq_pkg::ST_SAT: begin
        cmd.sat    = 1'b1;
        cmd.load_h = 1'b1;
        cmd.rd_en  = (sec_inc != used);
        rd_row     = sec + SEC_W'(2);
      end
      cbq_pkg::ST_PUSH: begin
        cmd.push = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // State, counters and section count register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cbq_pkg::ST_IDLE;
      tap           <= cbq_pkg::TAP_B0;
      sec           <= '0;
      section_count <= cbq_pkg::CNT_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        section_count <= cfg_wr_data;
      end
      if (state == cbq_pkg::ST_IDLE) begin
        sec <= '0;
      end else if (state == cbq_pkg::ST_SAT) begin
        sec <= sec_inc;
      end
      if (state == cbq_pkg::ST_MAC && tap != cbq_pkg::TAP_A2) begin
        tap <= cbq_pkg::tap_t'(tap + 3'd1);
      end else begin
        tap <= cbq_pkg::TAP_B0;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register is never overwritten while a result waits
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled result");

  // An accepted request starts with the row fetch
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == cbq_pkg::ST_LOAD))
    else $error("accepted request did not start");

  // A section finishes only after its last tap
  a_sat_after_taps: assert property (@(posedge clk) disable iff (rst)
    (state == cbq_pkg::ST_SAT) |-> ($past(state) == cbq_pkg::ST_MAC &&
                                    $past(tap) == cbq_pkg::TAP_A2))
    else $error("section finished early");

  // A result appears only from the push step
  a_valid_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == cbq_pkg::ST_PUSH))
    else $error("output valid without push");

endmodule
